@@ rtl/sm4_ctr_stream_cipher_macros.svh @@
// Assertion macros shared by the checker.
`ifndef SM4_CTR_STREAM_CIPHER_MACROS_SVH
`define SM4_CTR_STREAM_CIPHER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SM4_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sm4_pkg.sv @@
package sm4_pkg;

   localparam int unsigned NumRounds = 32;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   localparam logic [2:0] REG_KEY_UPPER = 3'd0;
   localparam logic [2:0] REG_KEY_LOWER = 3'd1;
   localparam logic [2:0] REG_NONCE     = 3'd2;
   localparam logic [2:0] REG_IV        = 3'd3;
   localparam logic [2:0] REG_START     = 3'd4;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       key_load;
      logic       key_round;
      logic       blk_load;
      logic       blk_round;
      logic       blk_done;
      logic [4:0] round;
   } sm4_cmd_type;

   function automatic logic [31:0] tau(input logic [31:0] a);
      tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
   endfunction

   function automatic logic [31:0] ck_word(input logic [4:0] i);
      logic [31:0] w;
      logic [7:0]  b;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         b = 8'(({i, 2'b00} + 8'(j)) * 8'd7);
         w = {w[23:0], b};
      end
      ck_word = w;
   endfunction

endpackage

@@ rtl/sm4_ctrl.sv @@
module sm4_ctrl
   import sm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tlast,
   input  logic        out_full,
   output logic        accept,
   output logic        emit,
   output sm4_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_KEY   = 4'b0010,
      ST_BLOCK = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] round_ff, round_in;
   logic [4:0] pos_ff, pos_in;
   logic       msg_ff, msg_in;
   logic       last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         pos_ff   <= 5'd16;
         msg_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pos_ff   <= pos_in;
         msg_ff   <= msg_in;
         last_ff  <= last_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      pos_in   = pos_ff;
      msg_in   = msg_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.round = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_tlast;
               round_in = '0;
               if (!msg_ff) begin
                  cmd.key_load = 1'b1;
                  pos_in       = 5'd16;
                  msg_in       = 1'b1;
                  state_in     = ST_KEY;
               end else if (pos_ff[4]) begin
                  cmd.blk_load = 1'b1;
                  state_in     = ST_BLOCK;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_KEY: begin
            cmd.key_round = 1'b1;
            round_in      = round_ff + 5'd1;
            if (round_ff == 5'(NumRounds - 1)) begin
               cmd.blk_load = 1'b1;
               state_in     = ST_BLOCK;
            end
         end
         ST_BLOCK: begin
            cmd.blk_round = 1'b1;
            round_in      = round_ff + 5'd1;
            if (round_ff == 5'(NumRounds - 1)) begin
               cmd.blk_done = 1'b1;
               pos_in       = '0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.round = pos_ff;
            pos_in    = pos_ff + 5'd1;
            if (last_ff) begin
               msg_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign emit = (state_ff == ST_EMIT);

endmodule

@@ rtl/sm4_datapath.sv @@
module sm4_datapath
   import sm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  sm4_cmd_type cmd,
   input  logic        emit,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [63:0] key_upper,
   input  logic [63:0] key_lower,
   input  logic [31:0] nonce_word,
   input  logic [63:0] iv_word,
   input  logic [31:0] start_count,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic        out_full
);

   logic [31:0] rk_mem [NumRounds];
   logic [31:0] rk_rd_ff;
   logic [31:0] k_ff [4];
   logic [31:0] x_ff [4];
   logic [31:0] nonce_ff;
   logic [63:0] iv_ff;
   logic [31:0] count_ff;
   logic [127:0] ks_ff;
   logic [7:0]  byte_ff;
   logic        lastin_ff;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff;
   logic        tlast_ff;
   logic [4:0]  rd_addr;
   logic [31:0] kt, kn, xt, xn;

   // Round keys are read into a register in the cycle before the round that uses them.
   always_comb begin
      rd_addr = cmd.round + 5'd1;
      if (cmd.blk_load) begin
         rd_addr = '0;
      end
   end

   assign kt = tau(k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ ck_word(cmd.round));
   assign kn = k_ff[0] ^ kt ^ {kt[18:0], kt[31:19]} ^ {kt[8:0], kt[31:9]};
   assign xt = tau(x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ rk_rd_ff);
   assign xn = x_ff[0] ^ xt ^ {xt[29:0], xt[31:30]} ^ {xt[21:0], xt[31:22]}
             ^ {xt[13:0], xt[31:14]} ^ {xt[7:0], xt[31:8]};

   always_ff @(posedge clock) begin
      if (cmd.key_round) begin
         rk_mem[cmd.round] <= kn;
      end
      rk_rd_ff <= rk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff   <= in_byte;
         lastin_ff <= in_last;
      end
      if (cmd.key_load) begin
         k_ff[0]  <= key_upper[63:32] ^ FK0;
         k_ff[1]  <= key_upper[31:0] ^ FK1;
         k_ff[2]  <= key_lower[63:32] ^ FK2;
         k_ff[3]  <= key_lower[31:0] ^ FK3;
         nonce_ff <= nonce_word;
         iv_ff    <= iv_word;
         count_ff <= start_count;
      end else if (cmd.key_round) begin
         k_ff[0] <= k_ff[1];
         k_ff[1] <= k_ff[2];
         k_ff[2] <= k_ff[3];
         k_ff[3] <= kn;
      end
      if (cmd.blk_load) begin
         x_ff[0] <= nonce_ff;
         x_ff[1] <= iv_ff[63:32];
         x_ff[2] <= iv_ff[31:0];
         x_ff[3] <= count_ff;
      end else if (cmd.blk_round) begin
         x_ff[0] <= x_ff[1];
         x_ff[1] <= x_ff[2];
         x_ff[2] <= x_ff[3];
         x_ff[3] <= xn;
      end
      if (cmd.blk_done) begin
         ks_ff    <= {xn, x_ff[3], x_ff[2], x_ff[1]};
         count_ff <= count_ff + 32'd1;
      end
      if (emit) begin
         data_ff  <= byte_ff ^ ks_ff[8'd127 - {cmd.round[3:0], 3'b000} -: 8];
         tlast_ff <= lastin_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = tlast_ff;
   assign out_full   = valid_ff && !rsp_tready;

endmodule

@@ rtl/sm4_regs.sv @@
module sm4_regs
   import sm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready,
   output logic [63:0] key_upper,
   output logic [63:0] key_lower,
   output logic [31:0] nonce_word,
   output logic [63:0] iv_word,
   output logic [31:0] start_count
);

   logic [63:0] key_upper_ff, key_lower_ff, iv_ff;
   logic [31:0] nonce_ff, start_ff;
   logic        wr;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         nonce_ff     <= 32'h001CC5B7;
         iv_ff        <= 64'h51A51D70A1C11148;
         start_ff     <= 32'd1;
      end else if (wr) begin
         unique case (idx)
            REG_KEY_UPPER: key_upper_ff <= csr_pwdata;
            REG_KEY_LOWER: key_lower_ff <= csr_pwdata;
            REG_NONCE:     nonce_ff     <= csr_pwdata[31:0];
            REG_IV:        iv_ff        <= csr_pwdata;
            REG_START:     start_ff     <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY_UPPER: csr_prdata = key_upper_ff;
         REG_KEY_LOWER: csr_prdata = key_lower_ff;
         REG_NONCE:     csr_prdata = {32'd0, nonce_ff};
         REG_IV:        csr_prdata = iv_ff;
         REG_START:     csr_prdata = {32'd0, start_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign key_upper   = key_upper_ff;
   assign key_lower   = key_lower_ff;
   assign nonce_word  = nonce_ff;
   assign iv_word     = iv_ff;
   assign start_count = start_ff;

endmodule

@@ rtl/sm4_ctr_stream_cipher.sv @@
// SM4-128 counter-mode byte cipher.
// Input items arrive on the req_ stream: one message byte in tdata, with
// tlast marking the final byte of a message. Each accepted item yields one
// result item on the rsp_ stream: the byte XORed with keystream, tlast copied.
// Key, nonce, IV and start counter are set through the csr_ APB port; the user
// must set them only while the block is idle, which the block does not enforce.
// They are sampled at the first byte of each message. The first byte of a
// message runs 32 key expansion rounds and 32 cipher rounds on one shared round
// unit each, plus load and output. Every sixteenth byte after that runs 32
// cipher rounds for a new keystream block, and the other bytes go straight to
// output. One item is worked on at a time; req_tready is high only when the
// round units are idle and the output register is free or being drained.
// If the receiver stalls, the result stays in the output register and no
// further item is taken. Reset clears the control state and the configuration
// registers to their defaults; the round key memory needs no clearing.
module sm4_ctr_stream_cipher
   import sm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // out_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0] key_upper, key_lower, iv_word;
   logic [31:0] nonce_word, start_count;
   sm4_cmd_type cmd;
   logic        accept, out_full, emit;

   sm4_regs u_regs (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .key_upper, .key_lower,
      .nonce_word, .iv_word, .start_count
   );

   sm4_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast, .out_full,
      .accept, .emit, .cmd
   );

   sm4_datapath u_dp (
      .clock, .reset, .cmd, .emit, .accept, .in_byte(req_tdata),
      .in_last(req_tlast), .key_upper, .key_lower, .nonce_word, .iv_word,
      .start_count, .rsp_tready, .rsp_tvalid, .rsp_tdata,
      .rsp_tlast, .out_full
   );

endmodule

@@ rtl/sm4_ctr_stream_cipher_checker.sv @@
`include "sm4_ctr_stream_cipher_macros.svh"

module sm4_ctr_stream_cipher_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic [7:0] rsp_tdata
);

   `SM4_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item dropped while stalled")

   `SM4_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready,
      !req_tready, "item taken while another is at work")

   `SM4_ASSERT_IMPL(a_no_take_when_stalled, clock, reset, rsp_tvalid && !rsp_tready,
      !req_tready, "item taken with result stalled")

endmodule

bind sm4_ctr_stream_cipher sm4_ctr_stream_cipher_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tlast, .rsp_tdata
);

@@ verif/sm4_ctr_stream_cipher_tb.sv @@
`timescale 1ns / 100ps

module sm4_ctr_stream_cipher_tb;
   import sm4_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } byte_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte
   logic        rsp_tlast;   // out_last
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   sm4_ctr_stream_cipher dut (.*);

   localparam logic [7:0] SBOX_TAB [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   logic [63:0]  cfg_key_upper, cfg_key_lower, cfg_iv;
   logic [31:0]  cfg_nonce, cfg_start;
   logic [31:0]  rk [32];
   logic [31:0]  ctr;
   logic [127:0] ks_block;
   logic [4:0]   ks_pos;
   logic         mid_message;
   logic [31:0]  msg_nonce;
   logic [63:0]  msg_iv;

   byte_item_type pending_bytes [$];
   byte_item_type expected_bytes [$];
   int           error_count;
   int           cycle_count;
   bit           hold_sender;
   bit           req_accepted;
   int           burst_left;
   int           gap_left;
   int           stall_mode;

   function automatic logic [31:0] sub_word(input logic [31:0] a);
      return {SBOX_TAB[a[31:24]], SBOX_TAB[a[23:16]], SBOX_TAB[a[15:8]], SBOX_TAB[a[7:0]]};
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] ck_const(input int i);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++)
         w = {w[23:0], 8'((4 * i + j) * 7)};
      return w;
   endfunction

   task automatic expand_round_keys();
      logic [31:0] k [4];
      logic [31:0] t, n;
      k[0] = cfg_key_upper[63:32] ^ 32'ha3b1bac6;
      k[1] = cfg_key_upper[31:0] ^ 32'h56aa3350;
      k[2] = cfg_key_lower[63:32] ^ 32'h677d9197;
      k[3] = cfg_key_lower[31:0] ^ 32'hb27022dc;
      for (int i = 0; i < 32; i++) begin
         t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
         n = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
         rk[i] = n;
         k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = n;
      end
   endtask

   task automatic encrypt_counter();
      logic [31:0] x [4];
      logic [31:0] t, n;
      x[0] = msg_nonce; x[1] = msg_iv[63:32]; x[2] = msg_iv[31:0]; x[3] = ctr;
      for (int i = 0; i < 32; i++) begin
         t = sub_word(x[1] ^ x[2] ^ x[3] ^ rk[i]);
         n = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
         x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = n;
      end
      ks_block = {x[3], x[2], x[1], x[0]};
      ctr = ctr + 32'd1;
   endtask

   task automatic predict_cipher_byte(input byte_item_type it);
      byte_item_type r;
      if (!mid_message) begin
         expand_round_keys();
         msg_nonce = cfg_nonce;
         msg_iv = cfg_iv;
         ctr = cfg_start;
         ks_pos = 5'd16;
         mid_message = 1'b1;
      end
      if (ks_pos >= 5'd16) begin
         encrypt_counter();
         ks_pos = 5'd0;
      end
      r.data_byte = it.data_byte ^ ks_block[127 - 8 * ks_pos[3:0] -: 8];
      r.last_byte = it.last_byte;
      ks_pos = ks_pos + 5'd1;
      if (it.last_byte)
         mid_message = 1'b0;
      expected_bytes.push_back(r);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("sm4_ctr_stream_cipher_tb: errors");
         $finish;
      end
   end

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_accepted)
            void'(pending_bytes.pop_front());
         if (req_tvalid && !req_accepted) begin
            req_tvalid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0 && !hold_sender) begin
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 40);
               if ($urandom_range(0, 2) == 0)
                  gap_left <= $urandom_range(0, 12);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_bytes[0].data_byte;
               req_tlast <= pending_bytes[0].last_byte;
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern changes mode from time to time.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      byte_item_type e;
      req_accepted <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_cipher_byte('{req_tdata, req_tlast});
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result item out_byte=%h out_last=%b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_tdata !== e.data_byte) begin
                  $error("out_byte expected %h actual %h", e.data_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== e.last_byte) begin
                  $error("out_last expected %b actual %b", e.last_byte, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_KEY_UPPER: cfg_key_upper = value;
         REG_KEY_LOWER: cfg_key_lower = value;
         REG_NONCE:     cfg_nonce = value[31:0];
         REG_IV:        cfg_iv = value;
         REG_START:     cfg_start = value[31:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic queue_message(input int len, input bit edge_bytes);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data_byte = edge_bytes ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom);
         it.last_byte = (i == len - 1);
         pending_bytes.push_back(it);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int sent;
      logic [31:0] sc;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      cfg_key_upper = '0; cfg_key_lower = '0;
      cfg_nonce = 32'h001CC5B7; cfg_iv = 64'h51A51D70A1C11148; cfg_start = 32'd1;
      ctr = '0; ks_block = '0; ks_pos = 5'd16; mid_message = 1'b0;
      msg_nonce = '0; msg_iv = '0;
      error_count = 0; cycle_count = 0; hold_sender = 0; req_accepted = 0;
      burst_left = 0; gap_left = 0; stall_mode = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults first, with alternating extreme bytes across a block boundary.
      queue_message(18, 1);
      wait_drained();

      // All-ones settings, counter about to wrap.
      csr_write(REG_KEY_UPPER, '1);
      csr_write(REG_KEY_LOWER, '1);
      csr_write(REG_NONCE, '1);
      csr_write(REG_IV, '1);
      csr_write(REG_START, 32'hFFFF_FFFF);
      queue_message(1, 0);
      queue_message(3, 1);
      wait_drained();

      // All-zero settings.
      csr_write(REG_KEY_UPPER, '0);
      csr_write(REG_KEY_LOWER, '0);
      csr_write(REG_NONCE, '0);
      csr_write(REG_IV, '0);
      csr_write(REG_START, '0);
      queue_message(2, 1);
      wait_drained();

      sent = 0;
      while (sent < 1350) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
            csr_write(REG_KEY_UPPER, rand64());
            csr_write(REG_KEY_LOWER, rand64());
            csr_write(REG_NONCE, {32'h0, $urandom});
            csr_write(REG_IV, rand64());
            sc = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom;
            csr_write(REG_START, {32'h0, sc});
         end
         if ($urandom_range(0, 9) == 0) begin
            hold_sender = 1'b1;
            while (expected_bytes.size() > 0 || req_tvalid)
               @(posedge clock);
            hold_sender = 1'b0;
         end
         begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 70);
            queue_message(len, 0);
            sent += len;
         end
         while (pending_bytes.size() > 40)
            @(posedge clock);
      end
      wait_drained();
      if (error_count == 0)
         $display("sm4_ctr_stream_cipher_tb: clean");
      else
         $display("sm4_ctr_stream_cipher_tb: errors");
      $finish;
   end

endmodule
